// File: src/first_fit_block_allocator_assert.svh
// assertion macros used by the allocator top level
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define FFBA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define FFBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: src/ffba_pkg.sv
// types, constants and codes of the first-fit block allocator
package ffba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 16;

    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W  = 20;
    localparam int SIZE_W  = 21;
    localparam int ENTRY_W = ADDR_W + SIZE_W + 1;

    // command queue between front and engine, power of two
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [SIZE_W-1:0] LIMIT_CAP   = 21'h100000;
    localparam logic [SIZE_W-1:0] LIMIT_RESET = 21'h100000;

    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_FREE   = 2'd1;
    localparam logic [1:0] REQ_RESIZE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO     = 2'd1;
    localparam logic [1:0] ST_NOSPACE  = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_RESIZE = 2'd2;
    localparam logic [1:0] CMD_IMM    = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] block_address;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic [1:0]        status;
    } t_rsp;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        imm_status;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
        logic              free;
    } t_entry;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [SIZE_W-1:0] brk;
    } t_eng_stat;

endpackage

// File: src/first_fit_block_allocator.sv
// first-fit heap block allocator without split or merge: top level
//
// request channel: i_req_valid / o_req_stall carry one i_req (type, size,
//   payload address); a request is taken on a clock edge with valid high and
//   stall low. a two-entry queue sits behind the intake, so requests keep
//   coming in while the engine works or while a response waits.
// response channel: o_rsp_valid / i_rsp_stall carry one o_rsp (address,
//   status) per request, in request order. a stalled response holds in the
//   output register; the engine then parks on its next result.
// config channel: i_cfg_valid / o_cfg_ready write the heap limit; write it
//   only while no request is in flight.
// timing: each table scan reads one entry per cycle from a single-port-read
//   ram. allocate and free each run one pass; an allocate that appends
//   writes one more entry after it; a resize that has to move runs two
//   passes. requests that need no table access skip the scan and go
//   straight to the result register. one request at a time.
// reset: synchronous active-low i_rst_n empties the table and the queue,
//   sets the break to zero and the limit to 1 MiB; table contents need no
//   clearing since only entries below the count are ever read.
`include "first_fit_block_allocator_assert.svh"

module first_fit_block_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_stall,
    input  ffba_pkg::t_req               i_req,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_stall,
    output ffba_pkg::t_rsp               o_rsp,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ffba_pkg::SIZE_W-1:0] i_cfg_data
);
    import ffba_pkg::*;

    logic [SIZE_W-1:0] r_heap_limit;
    logic              w_cmd_valid;
    t_cmd              w_cmd;
    logic              w_cmd_pop;
    t_eng_stat         w_stat;
    logic              w_rsp_fail;
    logic              w_rsp_grant;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_heap_limit <= i_cfg_data;
        end
    end

    ffba_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    ffba_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_limit     (r_heap_limit),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .i_rsp_stall (i_rsp_stall),
        .o_stat      (w_stat)
    );

    assign w_rsp_fail  = o_rsp_valid && (o_rsp.status != ST_OK);
    assign w_rsp_grant = o_rsp_valid && (o_rsp.result_address != '0);

    // any failing status comes with a null address
    `FFBA_ASSERT_IMP(a_err_null, w_rsp_fail, o_rsp.result_address == '0)

    // a granted address always lies past a header
    `FFBA_ASSERT_IMP(a_addr_hdr, w_rsp_grant, o_rsp.result_address >= ADDR_W'(HEADER_BYTES))

    // the table only grows, one block at a time
    `FFBA_ASSERT_NEXT(a_count_step, 1'b1, (w_stat.count - $past(w_stat.count)) <= CNT_W'(1))

    // empty table means nothing carved from the heap
    `FFBA_ASSERT_IMP(a_empty_brk, w_stat.count == '0, w_stat.brk == '0)

endmodule

// File: src/ffba_ram.sv
// generic single-write, single-read ram with registered read data
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/ffba_front.sv
// request intake: classifies each request and queues it for the engine
module ffba_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  ffba_pkg::t_req i_req,
    output logic          o_cmd_valid,
    output ffba_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);
    import ffba_pkg::*;

    t_cmd               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_fill;
    t_cmd               w_cmd;
    logic               w_push;
    logic               w_pop;

    always_comb begin
        w_cmd.kind       = CMD_IMM;
        w_cmd.imm_status = ST_OK;
        w_cmd.size       = i_req.request_size;
        w_cmd.addr       = i_req.block_address;
        case (i_req.req_type)
            REQ_ALLOC: begin
                if (i_req.request_size == '0) begin
                    w_cmd.imm_status = ST_ZERO;
                end else begin
                    w_cmd.kind = CMD_ALLOC;
                end
            end
            REQ_FREE: begin
                if (i_req.block_address != '0) begin
                    w_cmd.kind = CMD_FREE;
                end
            end
            REQ_RESIZE: begin
                // resize of null is a plain allocate
                if (i_req.block_address != '0) begin
                    w_cmd.kind = CMD_RESIZE;
                end else if (i_req.request_size == '0) begin
                    w_cmd.imm_status = ST_ZERO;
                end else begin
                    w_cmd.kind = CMD_ALLOC;
                end
            end
            default: begin
                w_cmd.kind = CMD_IMM;
            end
        endcase
    end

    assign o_req_stall = (r_fill == Q_CNT_W'(Q_DEPTH));
    assign w_push      = i_req_valid && !o_req_stall;
    assign o_cmd_valid = (r_fill != '0);
    assign w_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

// File: src/ffba_engine.sv
// execution engine: block table scans, append, free marking, result register
module ffba_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  ffba_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    input  logic [ffba_pkg::SIZE_W-1:0] i_limit,
    output logic               o_rsp_valid,
    output ffba_pkg::t_rsp      o_rsp,
    input  logic               i_rsp_stall,
    output ffba_pkg::t_eng_stat o_stat
);
    import ffba_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_APPEND   = 3'd2;
    localparam logic [2:0] S_FREE_OLD = 3'd3;
    localparam logic [2:0] S_DONE     = 3'd4;

    localparam logic M_FIND = 1'b0;
    localparam logic M_FIT  = 1'b1;

    logic [2:0]        r_state,     n_state;
    t_cmd              r_cmd,       n_cmd;
    logic              r_mode,      n_mode;
    logic              r_realloc,   n_realloc;
    logic [CNT_W-1:0]  r_rd_idx,    n_rd_idx;
    logic              r_chk_valid, n_chk_valid;
    logic [IDX_W-1:0]  r_chk_idx,   n_chk_idx;
    logic [IDX_W-1:0]  r_old_idx,   n_old_idx;
    t_entry            r_old,       n_old;
    logic [CNT_W-1:0]  r_count,     n_count;
    logic [SIZE_W-1:0] r_brk,       n_brk;
    t_rsp              r_res,       n_res;
    logic              r_out_valid, n_out_valid;
    t_rsp              r_out,       n_out;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    t_entry             ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    t_entry            w_rd;
    logic [SIZE_W-1:0] w_hdr_sum;
    logic              w_hit;
    logic [SIZE_W:0]   w_new_brk;
    logic [SIZE_W-1:0] w_limit;
    logic [ADDR_W-1:0] w_app_addr;
    logic              w_out_free;

    ffba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign w_rd      = t_entry'(ram_rdata);
    assign w_hdr_sum = {1'b0, w_rd.start} + SIZE_W'(HEADER_BYTES);
    assign w_hit     = r_chk_valid && ((r_mode == M_FIT)
                       ? (w_rd.free && (w_rd.size >= r_cmd.size))
                       : (w_hdr_sum == {1'b0, r_cmd.addr}));
    assign w_new_brk  = {1'b0, r_brk} + (SIZE_W+1)'(HEADER_BYTES) + {1'b0, r_cmd.size};
    assign w_limit    = (i_limit > LIMIT_CAP) ? LIMIT_CAP : i_limit;
    assign w_app_addr = r_brk[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
    assign w_out_free = !r_out_valid || !i_rsp_stall;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_mode      = r_mode;
        n_realloc   = r_realloc;
        n_rd_idx    = r_rd_idx;
        n_chk_valid = r_chk_valid;
        n_chk_idx   = r_chk_idx;
        n_old_idx   = r_old_idx;
        n_old       = r_old;
        n_count     = r_count;
        n_brk       = r_brk;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_rsp_stall;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_chk_idx;
        ram_wdata   = w_rd;
        ram_raddr   = r_rd_idx[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop   = 1'b1;
                    n_cmd       = i_cmd;
                    n_rd_idx    = '0;
                    n_chk_valid = 1'b0;
                    n_realloc   = 1'b0;
                    case (i_cmd.kind)
                        CMD_ALLOC: begin
                            n_mode  = M_FIT;
                            n_state = S_SCAN;
                        end
                        CMD_FREE, CMD_RESIZE: begin
                            n_mode  = M_FIND;
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_res   = '{result_address: '0, status: i_cmd.imm_status};
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // reads issue one per cycle, the previous entry is checked alongside
                if (w_hit) begin
                    n_chk_valid = 1'b0;
                    if (r_mode == M_FIT) begin
                        ram_we         = 1'b1;
                        ram_wdata.free = 1'b0;
                        n_res   = '{result_address: w_hdr_sum[ADDR_W-1:0], status: ST_OK};
                        n_state = r_realloc ? S_FREE_OLD : S_DONE;
                    end else begin
                        n_old_idx = r_chk_idx;
                        n_old     = w_rd;
                        if (r_cmd.kind == CMD_FREE) begin
                            ram_we         = 1'b1;
                            ram_wdata.free = 1'b1;
                            n_res   = '{result_address: '0, status: ST_OK};
                            n_state = S_DONE;
                        end else if (w_rd.free) begin
                            n_res   = '{result_address: '0, status: ST_NOTFOUND};
                            n_state = S_DONE;
                        end else if (w_rd.size >= r_cmd.size) begin
                            n_res   = '{result_address: r_cmd.addr, status: ST_OK};
                            n_state = S_DONE;
                        end else begin
                            // too small: second pass as an allocate
                            n_realloc = 1'b1;
                            n_mode    = M_FIT;
                            n_rd_idx  = '0;
                        end
                    end
                end else if (r_rd_idx < r_count) begin
                    n_rd_idx    = r_rd_idx + 1'b1;
                    n_chk_valid = 1'b1;
                    n_chk_idx   = r_rd_idx[IDX_W-1:0];
                end else if (!r_chk_valid) begin
                    if (r_mode == M_FIT) begin
                        n_state = S_APPEND;
                    end else begin
                        n_res   = '{result_address: '0, status: ST_NOTFOUND};
                        n_state = S_DONE;
                    end
                end else begin
                    n_chk_valid = 1'b0;
                end
            end
            S_APPEND: begin
                if ((r_count >= CNT_W'(MAX_BLOCKS)) || (w_new_brk > {1'b0, w_limit})) begin
                    n_res   = '{result_address: '0, status: ST_NOSPACE};
                    n_state = S_DONE;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_count[IDX_W-1:0];
                    ram_wdata = '{start: r_brk[ADDR_W-1:0], size: r_cmd.size, free: 1'b0};
                    n_count   = r_count + 1'b1;
                    n_brk     = w_new_brk[SIZE_W-1:0];
                    n_res     = '{result_address: w_app_addr, status: ST_OK};
                    n_state   = r_realloc ? S_FREE_OLD : S_DONE;
                end
            end
            S_FREE_OLD: begin
                ram_we         = 1'b1;
                ram_waddr      = r_old_idx;
                ram_wdata      = r_old;
                ram_wdata.free = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chk_valid <= 1'b0;
            r_count     <= '0;
            r_brk       <= '0;
            r_out_valid <= 1'b0;
            r_realloc   <= 1'b0;
            r_mode      <= M_FIND;
            r_rd_idx    <= '0;
        end else begin
            r_state     <= n_state;
            r_chk_valid <= n_chk_valid;
            r_count     <= n_count;
            r_brk       <= n_brk;
            r_out_valid <= n_out_valid;
            r_realloc   <= n_realloc;
            r_mode      <= n_mode;
            r_rd_idx    <= n_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_chk_idx <= n_chk_idx;
        r_old_idx <= n_old_idx;
        r_old     <= n_old;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_rsp_valid  = r_out_valid;
    assign o_rsp        = r_out;
    assign o_stat.count = r_count;
    assign o_stat.brk   = r_brk;

endmodule
